>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL modules of the datetime converter.
// Needs nothing else; modules include it by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

>>> rtl/utd_pkg.sv
// Types, constants and the month-length table for the datetime converter.
// Used by utd_ctrl, utd_datapath and unix_seconds_to_datetime.
`timescale 1ns / 1ps

package utd_pkg;

	localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
	localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
	localparam logic [16:0] SECS_PER_MIN  = 17'd60;

	// exact reciprocals: day = (s >> 7) / 675, hour = (s >> 4) / 225, min = (s >> 2) / 15
	localparam logic [25:0] RECIP_DAY        = 26'd50903317;
	localparam logic [13:0] RECIP_HOUR       = 14'd9321;
	localparam logic [10:0] RECIP_MIN        = 11'd1093;
	localparam int          RECIP_DAY_SHIFT  = 35;
	localparam int          RECIP_HOUR_SHIFT = 21;
	localparam int          RECIP_MIN_SHIFT  = 14;

	localparam logic [11:0] EPOCH_YEAR    = 12'd1970;
	localparam logic [1:0]  EPOCH_MOD4    = 2'd2;
	localparam logic [6:0]  EPOCH_MOD100  = 7'd70;
	localparam logic [8:0]  EPOCH_MOD400  = 9'd370;
	localparam logic [8:0]  DAYS_LEAP     = 9'd366;
	localparam logic [8:0]  DAYS_COMMON   = 9'd365;
	localparam logic [3:0]  MONTH_FIRST   = 4'd1;
	localparam logic [3:0]  MONTH_LAST    = 4'd12;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_DAY    = 7'b0000010,
		ST_HOUR   = 7'b0000100,
		ST_MIN    = 7'b0001000,
		ST_YEAR   = 7'b0010000,
		ST_MONTH  = 7'b0100000,
		ST_FINISH = 7'b1000000
	} state_t;

	typedef enum logic [1:0] {
		DIV_DAY,
		DIV_HOUR,
		DIV_MIN
	} div_sel_t;

	typedef struct packed {
		logic     load;
		logic     div_en;
		logic     rem_en;
		div_sel_t div_sel;
		logic     year_en;
		logic     month_en;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic zero;
		logic year_last;
		logic month_last;
	} sts_t;

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		if (m == 4'd2) begin
			len = leap ? 5'd29 : 5'd28;
		end else if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
			len = 5'd30;
		end else begin
			len = 5'd31;
		end
		return len;
	endfunction

endpackage

>>> rtl/utd_ctrl.sv
// Controller FSM: sequences the shared divider, year walk and month walk.
// Depends on utd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module utd_ctrl import utd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t     state_q, state_d;
	logic       step_q, step_d;
	logic       out_valid_q, out_valid_d;
	logic       slot_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || out_ready;

	// each division runs as a quotient step followed by a remainder step
	always_comb begin
		state_d     = state_q;
		step_d      = step_q;
		cmd         = '0;
		cmd.div_sel = DIV_DAY;
		out_valid_d = out_valid_q && !out_ready;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					step_d   = 1'b1;
					state_d  = ST_DAY;
				end
			end
			ST_DAY: begin
				if (sts.zero) begin
					state_d = ST_FINISH;
				end else begin
					cmd.div_sel = DIV_DAY;
					if (step_q) begin
						cmd.div_en = 1'b1;
						step_d     = 1'b0;
					end else begin
						cmd.rem_en = 1'b1;
						step_d     = 1'b1;
						state_d    = ST_HOUR;
					end
				end
			end
			ST_HOUR: begin
				cmd.div_sel = DIV_HOUR;
				if (step_q) begin
					cmd.div_en = 1'b1;
					step_d     = 1'b0;
				end else begin
					cmd.rem_en = 1'b1;
					step_d     = 1'b1;
					state_d    = ST_MIN;
				end
			end
			ST_MIN: begin
				cmd.div_sel = DIV_MIN;
				if (step_q) begin
					cmd.div_en = 1'b1;
					step_d     = 1'b0;
				end else begin
					cmd.rem_en = 1'b1;
					step_d     = 1'b1;
					state_d    = ST_YEAR;
				end
			end
			ST_YEAR: begin
				cmd.year_en = 1'b1;
				if (sts.year_last) begin
					state_d = ST_MONTH;
				end
			end
			ST_MONTH: begin
				cmd.month_en = 1'b1;
				if (sts.month_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					out_valid_d  = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			step_q      <= step_d;
			out_valid_q <= out_valid_d;
		end
	end

	`ASSERT_NEXT(a_accept_starts_div, clk, arst_n, in_valid && in_ready, state_q == ST_DAY)
	`ASSERT_NEXT(a_finish_delivers, clk, arst_n, state_q == ST_FINISH && slot_free, out_valid && in_ready)

endmodule

>>> rtl/utd_datapath.sv
// Datapath: zone offset register, reciprocal-multiply divider, year and month walk,
// and the result register. Depends on utd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module utd_datapath import utd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_offset,
	input  logic [31:0] unix_seconds,
	input  cmd_t        cmd,
	output sts_t        sts,
	output logic        valid_res,
	output logic [11:0] year,
	output logic [3:0]  month,
	output logic [4:0]  day,
	output logic [4:0]  hour,
	output logic [5:0]  minute,
	output logic [5:0]  second
);

	logic [15:0] offset_q;
	logic        zero_q;
	logic [31:0] num_q;
	logic [15:0] days_q;
	logic [4:0]  hour_q;
	logic [5:0]  min_q;
	logic [11:0] year_q;
	logic [1:0]  mod4_q;
	logic [6:0]  mod100_q;
	logic [8:0]  mod400_q;
	logic [3:0]  month_q;

	logic        res_valid_q;
	logic [11:0] res_year_q;
	logic [3:0]  res_month_q;
	logic [4:0]  res_day_q;
	logic [4:0]  res_hour_q;
	logic [5:0]  res_min_q;
	logic [5:0]  res_sec_q;

	logic [16:0] divisor;
	logic [15:0] day_quot;
	logic [4:0]  hour_quot;
	logic [5:0]  min_quot;
	logic [15:0] quot;
	logic [31:0] back;
	logic        leap;
	logic [8:0]  ylen;
	logic [4:0]  mlen;

	always_comb begin
		case (cmd.div_sel)
			DIV_DAY:  divisor = SECS_PER_DAY;
			DIV_HOUR: divisor = SECS_PER_HOUR;
			DIV_MIN:  divisor = SECS_PER_MIN;
			default:  divisor = SECS_PER_DAY;
		endcase
	end

	// num_q < 86400 before the hour step and < 3600 before the minute step
	assign day_quot  = 16'((51'(num_q[31:7]) * 51'(RECIP_DAY)) >> RECIP_DAY_SHIFT);
	assign hour_quot = 5'((27'(num_q[16:4]) * 27'(RECIP_HOUR)) >> RECIP_HOUR_SHIFT);
	assign min_quot  = 6'((21'(num_q[11:2]) * 21'(RECIP_MIN)) >> RECIP_MIN_SHIFT);

	always_comb begin
		case (cmd.div_sel)
			DIV_DAY:  quot = days_q;
			DIV_HOUR: quot = 16'(hour_q);
			DIV_MIN:  quot = 16'(min_q);
			default:  quot = days_q;
		endcase
	end

	assign back = 32'(quot) * 32'(divisor);

	assign leap  = (mod400_q == 9'd0) || ((mod100_q != 7'd0) && (mod4_q == 2'd0));
	assign ylen  = leap ? DAYS_LEAP : DAYS_COMMON;
	assign mlen  = month_len(month_q, leap);

	assign sts.zero       = zero_q;
	assign sts.year_last  = days_q < 16'(ylen);
	assign sts.month_last = days_q < 16'(mlen);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= 16'd0;
		end else if (cfg_we) begin
			offset_q <= cfg_offset;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			num_q    <= unix_seconds + 32'(offset_q);
			zero_q   <= (unix_seconds == 32'd0);
			year_q   <= EPOCH_YEAR;
			mod4_q   <= EPOCH_MOD4;
			mod100_q <= EPOCH_MOD100;
			mod400_q <= EPOCH_MOD400;
			month_q  <= MONTH_FIRST;
		end
		if (cmd.div_en) begin
			case (cmd.div_sel)
				DIV_DAY:  days_q <= day_quot;
				DIV_HOUR: hour_q <= hour_quot;
				DIV_MIN:  min_q  <= min_quot;
				default:  days_q <= day_quot;
			endcase
		end
		if (cmd.rem_en) begin
			num_q <= num_q - back;
		end
		if (cmd.year_en && !sts.year_last) begin
			days_q   <= days_q - 16'(ylen);
			year_q   <= year_q + 12'd1;
			mod4_q   <= mod4_q + 2'd1;
			mod100_q <= (mod100_q == 7'd99) ? 7'd0 : mod100_q + 7'd1;
			mod400_q <= (mod400_q == 9'd399) ? 9'd0 : mod400_q + 9'd1;
		end
		if (cmd.month_en && !sts.month_last) begin
			days_q  <= days_q - 16'(mlen);
			month_q <= month_q + 4'd1;
		end
		if (cmd.out_load) begin
			res_valid_q <= !zero_q;
			res_year_q  <= zero_q ? 12'd0 : year_q;
			res_month_q <= zero_q ? 4'd0 : month_q;
			res_day_q   <= zero_q ? 5'd0 : days_q[4:0] + 5'd1;
			res_hour_q  <= zero_q ? 5'd0 : hour_q;
			res_min_q   <= zero_q ? 6'd0 : min_q;
			res_sec_q   <= zero_q ? 6'd0 : num_q[5:0];
		end
	end

	assign valid_res = res_valid_q;
	assign year      = res_year_q;
	assign month     = res_month_q;
	assign day       = res_day_q;
	assign hour      = res_hour_q;
	assign minute    = res_min_q;
	assign second    = res_sec_q;

	`ASSERT_IMPLIES(a_month_in_range, clk, arst_n, cmd.month_en, month_q >= MONTH_FIRST && month_q <= MONTH_LAST)
	`ASSERT_IMPLIES(a_year_rem_fits, clk, arst_n, cmd.month_en, days_q < 16'(DAYS_LEAP))
	`ASSERT_IMPLIES(a_time_fields, clk, arst_n, cmd.out_load && !zero_q, hour_q < 5'd24 && min_q < 6'd60 && num_q < 32'd60)

endmodule

>>> rtl/unix_seconds_to_datetime.sv
// Unix timestamp to local Gregorian date and time: one request in, one result out.
// Top level; instantiates utd_ctrl and utd_datapath, depends on utd_pkg.
// A nonzero timestamp goes through division (a reciprocal multiply and then a
// multiply-back subtract for each of days, hours and minutes), the year walk,
// the month walk and the result write; the year walk dominates. A zero timestamp
// skips division and the walks, and finishes with valid_res 0 and all fields 0.
// One request is in work at a time; in_ready returns as soon as the result is
// registered, even if out_ready is low. zone_offset_seconds is written through
// the cfg channel (always ready); the user must write it only while the block is
// idle, which the block itself does not enforce. It resets to 0.
`timescale 1ns / 1ps

module unix_seconds_to_datetime import utd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] zone_offset_seconds,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] unix_seconds,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        valid_res,
	output logic [11:0] year,
	output logic [3:0]  month,
	output logic [4:0]  day,
	output logic [4:0]  hour,
	output logic [5:0]  minute,
	output logic [5:0]  second
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	utd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	utd_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_offset   (zone_offset_seconds),
		.unix_seconds (unix_seconds),
		.cmd          (cmd),
		.sts          (sts),
		.valid_res    (valid_res),
		.year         (year),
		.month        (month),
		.day          (day),
		.hour         (hour),
		.minute       (minute),
		.second       (second)
	);

endmodule

>>> bench/tb_unix_seconds_to_datetime.sv
// Self-checking bench for unix_seconds_to_datetime: random and directed timestamps
// under several zone offsets, checked against a local calendar predictor.
// Depends only on the RTL of unix_seconds_to_datetime and utd_pkg.
`timescale 1ns / 1ps

typedef struct packed {
	logic        valid_res;
	logic [11:0] year;
	logic [3:0]  month;
	logic [4:0]  day;
	logic [4:0]  hour;
	logic [5:0]  minute;
	logic [5:0]  second;
} datetime_t;

class datetime_scoreboard;
	datetime_t   expected_dates[$];
	logic [15:0] zone_offset = 16'd0;
	int unsigned errors = 0;
	int unsigned checked = 0;
	int unsigned zero_count = 0;

	function bit leap(int unsigned y);
		return ((y % 400) == 0) || (((y % 100) != 0) && ((y % 4) == 0));
	endfunction

	function int unsigned year_length(int unsigned y);
		return leap(y) ? 366 : 365;
	endfunction

	function int unsigned month_length(int unsigned y, int unsigned m);
		case (m)
			2: return leap(y) ? 29 : 28;
			4, 6, 9, 11: return 30;
			default: return 31;
		endcase
	endfunction

	function datetime_t local_datetime(logic [31:0] ts);
		datetime_t   r;
		logic [31:0] loc;
		int unsigned days, rem, y, m;
		r = '0;
		if (ts == 32'd0)
			return r;
		loc = ts + {16'd0, zone_offset};
		days = loc / 86400;
		rem = loc % 86400;
		r.hour = 5'(rem / 3600);
		rem = rem % 3600;
		r.minute = 6'(rem / 60);
		r.second = 6'(rem % 60);
		y = 1970;
		while (days >= year_length(y)) begin
			days -= year_length(y);
			y++;
		end
		m = 1;
		while (m <= 12 && days >= month_length(y, m)) begin
			days -= month_length(y, m);
			m++;
		end
		r.valid_res = 1'b1;
		r.year = 12'(y);
		r.month = 4'(m);
		r.day = 5'(days + 1);
		return r;
	endfunction

	function void note_request(logic [31:0] ts);
		expected_dates.push_back(local_datetime(ts));
		if (ts == 32'd0)
			zero_count++;
	endfunction

	task report_mismatch(string what, int unsigned want_v, int unsigned got_v);
		errors++;
		if (errors <= 25)
			$display("MISMATCH result %0d %s: expected %0d got %0d", checked, what, want_v, got_v);
	endtask

	task check_result(datetime_t got);
		datetime_t want;
		if (expected_dates.size() == 0) begin
			report_mismatch("result with no request pending", 0, 0);
			return;
		end
		want = expected_dates.pop_front();
		checked++;
		if (got.valid_res !== want.valid_res)
			report_mismatch("valid_res", want.valid_res, got.valid_res);
		if (got.year !== want.year)
			report_mismatch("year", want.year, got.year);
		if (got.month !== want.month)
			report_mismatch("month", want.month, got.month);
		if (got.day !== want.day)
			report_mismatch("day", want.day, got.day);
		if (got.hour !== want.hour)
			report_mismatch("hour", want.hour, got.hour);
		if (got.minute !== want.minute)
			report_mismatch("minute", want.minute, got.minute);
		if (got.second !== want.second)
			report_mismatch("second", want.second, got.second);
	endtask
endclass

module tb_unix_seconds_to_datetime;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] zone_offset_seconds = 16'd0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [31:0] unix_seconds = 32'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        valid_res;
	logic [11:0] year;
	logic [3:0]  month;
	logic [4:0]  day;
	logic [4:0]  hour;
	logic [5:0]  minute;
	logic [5:0]  second;
	logic        steady = 1'b0;

	datetime_scoreboard dates = new;

	unix_seconds_to_datetime DUT (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_valid           (cfg_valid),
		.cfg_ready           (cfg_ready),
		.zone_offset_seconds (zone_offset_seconds),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.unix_seconds        (unix_seconds),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.valid_res           (valid_res),
		.year                (year),
		.month               (month),
		.day                 (day),
		.hour                (hour),
		.minute              (minute),
		.second              (second)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// mostly short gaps, a few long ones; none in steady stretches
	function automatic int unsigned idle_gap();
		int unsigned r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [31:0] random_timestamp();
		logic [31:0] ts;
		case ($urandom_range(0, 9))
			5: ts = $urandom_range(0, 200000);
			6: ts = 32'hFFFF_FFFF - $urandom_range(0, 200000);
			7: ts = $urandom_range(0, 49710) * 86400 + $urandom_range(0, 4) - 2;
			8: ts = $urandom_range(0, 3);
			9: ts = $urandom() & 32'h7FFF_FFFF;
			default: ts = $urandom();
		endcase
		return ts;
	endfunction

	task automatic send_timestamp(input logic [31:0] ts);
		int unsigned gap;
		gap = idle_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			unix_seconds <= $urandom();
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		unix_seconds <= ts;
		do @(posedge clk); while (!in_ready);
		dates.note_request(ts);
	endtask

	// only while idle: every result back
	task automatic write_zone_offset(input logic [15:0] v);
		in_valid <= 1'b0;
		while (dates.expected_dates.size() != 0) @(posedge clk);
		cfg_valid <= 1'b1;
		zone_offset_seconds <= v;
		do @(posedge clk); while (!cfg_ready);
		dates.zone_offset = v;
		cfg_valid <= 1'b0;
	endtask

	// receiver: random stalls, plus two long hold-offs to back up the request side
	initial begin
		int unsigned stall;
		stall = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				dates.check_result({valid_res, year, month, day, hour, minute, second});
				if (dates.checked == 150 || dates.checked == 900)
					stall = 500;
			end
			if (stall == 0)
				stall = idle_gap();
			if (stall != 0) begin
				out_ready <= 1'b0;
				stall--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		logic [15:0] offsets[5];
		logic [31:0] epoch_cases[$];
		logic [31:0] wrap_cases[$];
		int unsigned ph, k;
		epoch_cases = '{32'd0, 32'd1, 32'd59, 32'd3599, 32'd86399, 32'd86400,
			32'd31535999, 32'd31536000, 32'd68169600, 32'd946684800, 32'd951782400,
			32'd4107542400, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555};
		wrap_cases = '{32'hFFFF_0000, 32'hFFFF_0001, 32'd0, 32'd1, 32'hFFFF_FFFF};
		offsets = '{16'd0, 16'd50400, 16'hFFFF, 16'd0, 16'd0};
		offsets[3] = 16'($urandom());
		offsets[4] = 16'($urandom_range(1, 50399));
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (ph = 0; ph < 5; ph++) begin
			write_zone_offset(offsets[ph]);
			if (ph == 0) begin
				foreach (epoch_cases[i])
					send_timestamp(epoch_cases[i]);
			end else if (ph == 1) begin
				// nonzero request landing on local time zero, and a wrap
				send_timestamp(32'hFFFF_3B20);
				send_timestamp(32'hFFFF_FFFF);
			end else if (ph == 2) begin
				foreach (wrap_cases[i])
					send_timestamp(wrap_cases[i]);
			end
			for (k = 0; k < 376; k++) begin
				if (k % 50 == 0)
					steady <= ($urandom_range(0, 3) == 0);
				send_timestamp(random_timestamp());
			end
		end
		in_valid <= 1'b0;
		while (dates.expected_dates.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("Checked %0d conversions under 5 zone offsets, %0d of them zero timestamps.",
			dates.checked, dates.zero_count);
		$display("Covered offset wrap, leap days, field extremes and long output back-pressure.");
		if (dates.errors == 0 && dates.expected_dates.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl
rtl/utd_pkg.sv
rtl/utd_ctrl.sv
rtl/utd_datapath.sv
rtl/unix_seconds_to_datetime.sv
bench/tb_unix_seconds_to_datetime.sv
